FILE: src/u2d_pkg.sv
package u2d_pkg;

  // Byte classes of UTF-8
  localparam logic [7:0] ContMask   = 8'hC0;
  localparam logic [7:0] ContCode   = 8'h80;
  localparam logic [7:0] Lead2Mask  = 8'hE0;
  localparam logic [7:0] Lead2Code  = 8'hC0;
  localparam logic [7:0] Lead3Mask  = 8'hF0;
  localparam logic [7:0] Lead3Code  = 8'hE0;
  localparam logic [7:0] FieldTerm  = 8'h00;
  localparam logic [15:0] SpaceUnit = 16'h0020;

  // Number of bytes held towards a multi-byte sequence
  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_LEAD = 2'd1,
    PEND_CONT = 2'd2
  } pend_cnt_t;

  typedef struct packed {
    logic [7:0] lead;
    logic [7:0] cont;
    pend_cnt_t  count;
  } pend_t;

  typedef struct packed {
    logic        emit;
    logic [15:0] code_unit;
    logic        field_end;
  } dec_res_t;

  function automatic logic is_cont(input logic [7:0] b);
    return (b & ContMask) == ContCode;
  endfunction

  function automatic logic is_lead2(input logic [7:0] b);
    return (b & Lead2Mask) == Lead2Code;
  endfunction

  function automatic logic is_lead3(input logic [7:0] b);
    return (b & Lead3Mask) == Lead3Code;
  endfunction

endpackage

FILE: src/u2d_decode.sv
// Next-state and result logic for one byte against the held sequence.
module u2d_decode (
  input  u2d_pkg::pend_t    pend,
  input  logic [7:0]        byte_in,
  output u2d_pkg::pend_t    pend_nxt,
  output u2d_pkg::dec_res_t res
);

  logic cont_ok;

  assign cont_ok = u2d_pkg::is_cont(byte_in);

  always_comb begin
    pend_nxt      = '{lead: 8'h00, cont: 8'h00, count: u2d_pkg::PEND_NONE};
    res.emit      = 1'b0;
    res.code_unit = 16'h0000;
    res.field_end = 1'b0;
    if (pend.count == u2d_pkg::PEND_LEAD && cont_ok) begin
      if (u2d_pkg::is_lead2(pend.lead)) begin
        res.emit      = 1'b1;
        res.code_unit = {5'b00000, pend.lead[4:0], byte_in[5:0]};
      end else begin
        pend_nxt.lead  = pend.lead;
        pend_nxt.cont  = byte_in;
        pend_nxt.count = u2d_pkg::PEND_CONT;
      end
    end else if (pend.count == u2d_pkg::PEND_CONT && cont_ok) begin
      res.emit      = 1'b1;
      res.code_unit = {pend.lead[3:0], pend.cont[5:0], byte_in[5:0]};
    end else begin
      // Nothing held, or the held lead lacks its continuation: start afresh.
      if (byte_in == u2d_pkg::FieldTerm) begin
        res.emit      = 1'b1;
        res.code_unit = u2d_pkg::SpaceUnit;
        res.field_end = 1'b1;
      end else if (!byte_in[7]) begin
        res.emit      = 1'b1;
        res.code_unit = {8'h00, byte_in};
      end else if (u2d_pkg::is_lead2(byte_in) || u2d_pkg::is_lead3(byte_in)) begin
        pend_nxt.lead  = byte_in;
        pend_nxt.count = u2d_pkg::PEND_LEAD;
      end
    end
  end

endmodule

FILE: src/utf8_to_ucs2_decoder.sv
// An accepted input beat passes through the input register and decode logic into the output register.
// Throughput: one byte per cycle; the input register, decode logic and result register
// form a two-stage pipeline that advances whenever the result register is free or taken.
// Bytes that produce no character (leads, stray bytes) leave the pipeline without a beat.
// Reset (rst_n low, synchronous) empties both stages and clears the held sequence.
module utf8_to_ucs2_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] code_unit
  output logic        out_tlast   // field_end
);

  // Input register stage.
  logic       in_vld_r;
  logic [7:0] in_byte_r;

  // Bytes held towards a multi-byte sequence.
  u2d_pkg::pend_t pend_r;
  u2d_pkg::pend_t pend_nxt;

  // Result register stage.
  logic        out_vld_r;
  logic [15:0] out_unit_r;
  logic        out_last_r;

  u2d_pkg::dec_res_t res;
  logic              out_free;
  logic              advance;

  u2d_decode u_decode (
    .pend     (pend_r),
    .byte_in  (in_byte_r),
    .pend_nxt (pend_nxt),
    .res      (res)
  );

  // The result register can take a new value when it is empty or being read
  // this cycle. The decoded byte moves on only then, so the held sequence
  // and the result always stay in step.
  assign out_free  = !out_vld_r || out_tready;
  assign advance   = in_vld_r && out_free;
  assign in_tready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '{lead: 8'h00, cont: 8'h00, count: u2d_pkg::PEND_NONE};
    end else if (advance) begin
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= advance && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.emit) begin
      out_unit_r <= res.code_unit;
      out_last_r <= res.field_end;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_unit_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

  // One expected result beat: the decoded unit and the field-end marker.
  typedef struct packed {
    logic [15:0] code_unit;
    logic        field_end;
  } ucs2_unit_t;

  // Tracks the decoder's held sequence and keeps the code units that the
  // accepted bytes must produce, in order.
  class ucs2_scoreboard;
    logic [7:0]         held_lead;
    logic [7:0]         held_cont;
    u2d_pkg::pend_cnt_t held_count;
    ucs2_unit_t         units_due[$];
    int                 n_errors;

    function new();
      clear_held();
      n_errors = 0;
    endfunction

    function void clear_held();
      held_lead  = 8'h00;
      held_cont  = 8'h00;
      held_count = u2d_pkg::PEND_NONE;
    endfunction

    // Called for every byte the decoder accepts.
    function void note_byte(logic [7:0] b);
      logic       cont_b;
      logic       emit;
      ucs2_unit_t u;
      cont_b = (b & u2d_pkg::ContMask) == u2d_pkg::ContCode;
      emit   = 1'b0;
      u      = '0;
      if (held_count == u2d_pkg::PEND_LEAD && cont_b) begin
        if ((held_lead & u2d_pkg::Lead2Mask) == u2d_pkg::Lead2Code) begin
          u.code_unit = {5'b0, held_lead[4:0], b[5:0]};
          emit = 1'b1;
          clear_held();
        end else begin
          held_cont  = b;
          held_count = u2d_pkg::PEND_CONT;
        end
      end else if (held_count == u2d_pkg::PEND_CONT && cont_b) begin
        u.code_unit = {held_lead[3:0], held_cont[5:0], b[5:0]};
        emit = 1'b1;
        clear_held();
      end else begin
        // Anything held is abandoned and the byte is taken as a fresh start.
        clear_held();
        if (b == u2d_pkg::FieldTerm) begin
          u.code_unit = u2d_pkg::SpaceUnit;
          u.field_end = 1'b1;
          emit = 1'b1;
        end else if (!b[7]) begin
          u.code_unit = {8'h00, b};
          emit = 1'b1;
        end else if ((b & u2d_pkg::Lead2Mask) == u2d_pkg::Lead2Code ||
                     (b & u2d_pkg::Lead3Mask) == u2d_pkg::Lead3Code) begin
          held_lead  = b;
          held_count = u2d_pkg::PEND_LEAD;
        end
      end
      if (emit) units_due = {units_due, u};
    endfunction

    task flag_error(string msg);
      $display("tb: mismatch at %0t: %s", $realtime, msg);
      n_errors++;
    endtask

    // Called for every result beat taken from the decoder.
    task check_unit(logic [15:0] data, logic last);
      ucs2_unit_t want;
      if (units_due.size() == 0) begin
        flag_error($sformatf("unit %h last %b with nothing expected", data, last));
        return;
      end
      want = units_due.pop_front();
      if (data !== want.code_unit)
        flag_error($sformatf("code unit %h, expected %h", data, want.code_unit));
      if (last !== want.field_end)
        flag_error($sformatf("field end %b, expected %b", last, want.field_end));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        out_tlast;

  ucs2_scoreboard sb = new();

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int send_idle;
  int recv_stall;
  int n_sent;

  // Directed opening: plain ASCII at both ends of its range, two- and
  // three-byte forms including the smallest and largest results, an overlong
  // form, stray bytes, leads whose continuation is missing, and fields that
  // end in the middle of a sequence with one or two bytes held.
  logic [7:0] opening_bytes[$] = '{
    8'h00, 8'h41, 8'h7F,
    8'hC2, 8'hA9,
    8'hE2, 8'h82, 8'hAC,
    8'hEF, 8'hBF, 8'hBF,
    8'hC0, 8'h80,
    8'h80, 8'hFF,
    8'hC3, 8'h41,
    8'hE1, 8'h80, 8'hC3, 8'hA0,
    8'hE1, 8'h80, 8'h00,
    8'hC5, 8'h00
  };

  utf8_to_ucs2_decoder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [7:0] in_byte
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [15:0] code_unit
    .out_tlast  (out_tlast)    // field_end
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Offers one byte, idling beforehand at the current rate, and returns once
  // the beat has been taken. The valid is left high so that back-to-back
  // bytes need no second assignment in the same step.
  task send_byte(logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom_range(255));
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_byte(b);
    n_sent++;
  endtask

  function logic [7:0] rand_cont();
    return {2'b10, 6'($urandom_range(63))};
  endfunction

  // Mostly well-formed characters and field ends with random content; the
  // rest are broken sequences and raw noise.
  task send_random_sequence();
    int         kind;
    logic [7:0] b;
    kind = $urandom_range(99);
    if (kind < 30) begin
      send_byte(8'($urandom_range(1, 127)));
    end else if (kind < 50) begin
      send_byte({3'b110, 5'($urandom_range(31))});
      send_byte(rand_cont());
    end else if (kind < 70) begin
      send_byte({4'b1110, 4'($urandom_range(15))});
      send_byte(rand_cont());
      send_byte(rand_cont());
    end else if (kind < 78) begin
      send_byte(u2d_pkg::FieldTerm);
    end else if (kind < 90) begin
      // A lead whose sequence is cut short by a byte that is not a
      // continuation; a three-byte lead sometimes gets one continuation first.
      if ($urandom_range(1)) begin
        send_byte({3'b110, 5'($urandom_range(31))});
      end else begin
        send_byte({4'b1110, 4'($urandom_range(15))});
        if ($urandom_range(1)) send_byte(rand_cont());
      end
      b = 8'($urandom_range(255));
      if ((b & u2d_pkg::ContMask) == u2d_pkg::ContCode) b[6] = 1'b1;
      if ($urandom_range(7) == 0) b = u2d_pkg::FieldTerm;
      send_byte(b);
    end else begin
      send_byte(8'($urandom_range(255)));
    end
  endtask

  // Receiver: takes result beats and stalls at the current rate. Values are
  // sampled as they stood before the edge.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_unit(out_tdata, out_tlast);
    out_tready <= ($urandom_range(99) >= recv_stall);
  end

  initial begin
    int phase;
    in_tvalid  <= 1'b0;
    in_tdata   <= 8'h00;
    out_tready <= 1'b0;
    rst_n      <= 1'b0;
    send_idle  = 0;
    recv_stall = 0;
    n_sent     = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening_bytes[i]) send_byte(opening_bytes[i]);

    // Four idling phases of roughly equal length: none, sender only,
    // receiver only, then both together.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 62; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 62; end
        default: begin send_idle = 30; recv_stall = 30; end
      endcase
      while (n_sent < opening_bytes.size() + 213 * (phase + 1))
        send_random_sequence();
      if (phase == 1) begin
        // Hold the input off until the decoder has delivered everything owed.
        in_tvalid <= 1'b0;
        do @(posedge clk); while (sb.units_due.size() != 0);
      end
    end

    in_tvalid <= 1'b0;
    while (sb.units_due.size() != 0) @(posedge clk);
    // Allow for the two-stage pipeline to show any surplus beat.
    repeat (10) @(posedge clk);
    if (sb.n_errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Overall limit, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
